// ===== rtl/core/mwrg_pkg.sv =====
// Package for the mass-weighted radius of gyration block.
// Types and fixed widths shared by front end, back end and top level.
`default_nettype none
package mwrg_pkg;
   localparam int CoordW = 24;
   localparam int MassW  = 16;
   localparam int RadW   = 26;
   localparam int WsumW  = 58;
   localparam int MtotW  = 34;
   localparam int AccW   = 120;
   localparam int QuotW  = 64;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic [MassW-1:0]         m;
      logic                     store;
      logic                     last;
   } atom_type;

   typedef struct packed {
      logic [RadW-1:0] radius;
      logic            zero_mass;
      logic            atoms_dropped;
   } result_type;
endpackage
`default_nettype wire

// ===== rtl/core/mass_weighted_radius_of_gyration.sv =====
// Mass-weighted radius of gyration, top level.
// Atoms enter on req_*, one per transaction; req_tlast closes a frame.
// Up to MAX_ATOMS atoms are stored; extras are dropped and flagged.
// Atoms load one per cycle via a two-entry front queue until a frame closes.
// Closing a frame: three center divisions, then a second pass over
// the stored atoms (read, offset, square, accumulate), a final divide
// and a square root, then one result transaction on rsp_*.
// Zero total mass skips the math and returns radius 0 with zero_mass.
// The result register holds while rsp_tready is low; atoms of the next
// frame keep loading, but its math waits until the result is taken,
// and req_tready falls when the front queue fills.
// Synchronous reset clears counts, sums and flags; atom storage is
// left as is and only read where written in the current frame.
// Depends on mwrg_pkg, mwrg_front and mwrg_back.
`default_nettype none
module mass_weighted_radius_of_gyration #(
   parameter int MAX_ATOMS = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [87:0] req_tdata,  // x_coord, y_coord, z_coord, atom_mass
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,  // radius, zero_mass, atoms_dropped, zero pad
   output logic        rsp_tlast
);
   mwrg_pkg::atom_type   in_atom, q_atom;
   mwrg_pkg::result_type res;
   logic q_valid, q_ready;

   always_comb begin
      in_atom.x     = req_tdata[23:0];
      in_atom.y     = req_tdata[47:24];
      in_atom.z     = req_tdata[71:48];
      in_atom.m     = req_tdata[87:72];
      in_atom.store = 1'b0;
      in_atom.last  = req_tlast;
   end

   mwrg_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_atom(in_atom),
      .q_valid(q_valid), .q_ready(q_ready), .q_atom(q_atom));

   mwrg_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_atom(q_atom),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res));

   assign rsp_tdata = {4'd0, res.atoms_dropped, res.zero_mass, res.radius};
   assign rsp_tlast = 1'b1;
endmodule
`default_nettype wire

// ===== rtl/core/mwrg_front.sv =====
// Front end: accepts atoms, decides whether each one is stored or dropped.
// Depends on mwrg_pkg. Feeds a two-entry queue toward the back end.
`default_nettype none
module mwrg_front #(
   parameter int MAX_ATOMS = 1024
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire  mwrg_pkg::atom_type in_atom,
   output logic                     q_valid,
   input  wire                      q_ready,
   output mwrg_pkg::atom_type       q_atom
);
   localparam int CntW = $clog2(MAX_ATOMS + 1);
   logic [CntW-1:0] count_ff, count_in;
   mwrg_pkg::atom_type buf_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   mwrg_pkg::atom_type cls;

   assign in_ready = (fill_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (fill_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_atom   = buf_ff[rd_ff];

   always_comb begin
      cls       = in_atom;
      cls.store = (count_ff < CntW'(MAX_ATOMS));
      count_in  = count_ff;
      if (push) begin
         if (in_atom.last) count_in = '0;
         else if (cls.store) count_in = count_ff + 1'b1;
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
      rd_in   = pop ? ~rd_ff : rd_ff;
      wr_in   = push ? ~wr_ff : wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) buf_ff[wr_ff] <= cls;
   end
endmodule
`default_nettype wire

// ===== rtl/core/mwrg_back.sv =====
// Back end: stores atoms, accumulates sums, then runs the center divide,
// second pass, final divide and square root. Depends on mwrg_pkg.
`default_nettype none
module mwrg_back #(
   parameter int MAX_ATOMS = 1024
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        q_valid,
   output logic                       q_ready,
   input  wire  mwrg_pkg::atom_type   q_atom,
   output logic                       res_valid,
   input  wire                        res_ready,
   output mwrg_pkg::result_type       res
);
   localparam int AddrW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CntW  = $clog2(MAX_ATOMS + 1);
   localparam int WsW   = mwrg_pkg::WsumW;
   localparam int MtW   = mwrg_pkg::MtotW;
   localparam int AcW   = mwrg_pkg::AccW;
   localparam int QW    = mwrg_pkg::QuotW;

   localparam logic [3:0] S_LOAD = 4'd0, S_CDIV = 4'd1, S_CFIN = 4'd2,
      S_RD = 4'd3, S_SQ = 4'd4, S_MUL = 4'd5, S_ACC = 4'd6, S_DIV = 4'd7,
      S_SQRT = 4'd8, S_OUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic signed [mwrg_pkg::CoordW-1:0] xm [MAX_ATOMS];
   logic signed [mwrg_pkg::CoordW-1:0] ym [MAX_ATOMS];
   logic signed [mwrg_pkg::CoordW-1:0] zm [MAX_ATOMS];
   logic [mwrg_pkg::MassW-1:0]         mm [MAX_ATOMS];
   logic signed [mwrg_pkg::CoordW-1:0] xr_ff, yr_ff, zr_ff;
   logic [mwrg_pkg::MassW-1:0]         mr_ff;

   logic [CntW-1:0] cnt_ff, idx_ff;
   logic signed [WsW-1:0] wx_ff, wy_ff, wz_ff;
   logic [MtW-1:0] mt_ff;
   logic           ovf_ff, drop_ff, pstage_ff;
   logic [1:0]     axis_ff;
   logic [6:0]     step_ff;
   logic [WsW:0]   rem_ff, mag_ff;
   logic           neg_ff;
   logic signed [26:0] cx_ff, cy_ff, cz_ff;
   logic signed [25:0] dx_ff, dy_ff, dz_ff;
   logic [51:0] d2_ff;
   logic [AcW-1:0] acc_ff, num_ff;
   logic [QW-1:0]  dq_ff;
   logic [MtW:0]   drem_ff;
   logic [QW-1:0]  sv_ff, sres_ff, sbit_ff;
   mwrg_pkg::result_type res_ff;
   logic rv_ff;

   logic take;
   logic signed [40:0] px, py, pz;
   logic [WsW:0] rsh, rdiff, half_mt;
   logic [MtW:0] dsh;
   logic [MtW+1:0] dtry;
   logic [QW-1:0]  ssum;
   logic signed [26:0] qsg;
   logic [QW-1:0]  qfin;
   logic [67:0]    prod;
   logic [AcW-1:0] mac;

   assign q_ready   = (state_ff == S_LOAD) && !pstage_ff;
   assign take      = q_valid && q_ready;
   assign res_valid = rv_ff;
   assign res       = res_ff;

   assign px      = 41'(q_atom.x) * 41'($signed({1'b0, q_atom.m}));
   assign py      = 41'(q_atom.y) * 41'($signed({1'b0, q_atom.m}));
   assign pz      = 41'(q_atom.z) * 41'($signed({1'b0, q_atom.m}));
   assign half_mt = {{(WsW+2-MtW){1'b0}}, mt_ff[MtW-1:1]};
   assign rsh   = {rem_ff[WsW-1:0], mag_ff[WsW]};
   assign rdiff = rsh - {{(WsW+1-MtW){1'b0}}, mt_ff};
   assign dsh   = {drem_ff[MtW-1:0], num_ff[AcW-1]};
   assign dtry  = {1'b0, dsh} - {2'b0, mt_ff};
   assign ssum  = sres_ff + sbit_ff;
   assign qsg   = neg_ff ? -27'(mag_ff) : 27'(mag_ff);
   assign qfin  = {dq_ff[QW-2:0], ~dtry[MtW+1]};
   assign prod  = 68'(d2_ff) * 68'(mr_ff);
   assign mac   = acc_ff + AcW'(prod);

   always_ff @(posedge clock) begin
      if (take && q_atom.store) begin
         xm[cnt_ff[AddrW-1:0]] <= q_atom.x;
         ym[cnt_ff[AddrW-1:0]] <= q_atom.y;
         zm[cnt_ff[AddrW-1:0]] <= q_atom.z;
         mm[cnt_ff[AddrW-1:0]] <= q_atom.m;
      end
      if (state_ff == S_RD) begin
         xr_ff <= xm[idx_ff[AddrW-1:0]];
         yr_ff <= ym[idx_ff[AddrW-1:0]];
         zr_ff <= zm[idx_ff[AddrW-1:0]];
         mr_ff <= mm[idx_ff[AddrW-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: if (pstage_ff && !rv_ff) state_in = (mt_ff == '0) ? S_OUT : S_CDIV;
         S_CDIV: if (step_ff == 7'(WsW)) state_in = S_CFIN;
         S_CFIN: state_in = (axis_ff == 2'd2) ? S_RD : S_CDIV;
         S_RD:   state_in = S_SQ;
         S_SQ:   state_in = S_MUL;
         S_MUL:  state_in = S_ACC;
         S_ACC:  state_in = (idx_ff == cnt_ff) ? S_DIV : S_RD;
         S_DIV:  if (step_ff == 7'(AcW - 1)) state_in = S_SQRT;
         S_SQRT: if (sbit_ff == '0) state_in = S_OUT;
         S_OUT:  state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; wx_ff <= '0; wy_ff <= '0; wz_ff <= '0;
         mt_ff <= '0; ovf_ff <= 1'b0; pstage_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rv_ff && res_ready) rv_ff <= 1'b0;
         if (take) begin
            pstage_ff <= q_atom.last;
            drop_ff   <= ovf_ff || !q_atom.store;
            if (q_atom.store) begin
               cnt_ff <= cnt_ff + 1'b1;
               mt_ff  <= mt_ff + MtW'(q_atom.m);
               wx_ff  <= wx_ff + WsW'(px);
               wy_ff  <= wy_ff + WsW'(py);
               wz_ff  <= wz_ff + WsW'(pz);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         case (state_ff)
            S_LOAD: if (pstage_ff && !rv_ff) begin
               axis_ff <= 2'd0; step_ff <= '0; rem_ff <= '0; idx_ff <= '0;
               neg_ff  <= wx_ff[WsW-1];
               mag_ff  <= (wx_ff[WsW-1] ? -{wx_ff[WsW-1], wx_ff} : {1'b0, wx_ff})
                          + half_mt;
            end
            S_CDIV: begin
               step_ff <= step_ff + 1'b1;
               if (!rdiff[WsW]) rem_ff <= rdiff; else rem_ff <= rsh;
               mag_ff <= {mag_ff[WsW-1:0], ~rdiff[WsW]};
            end
            S_CFIN: begin
               case (axis_ff)
                  2'd0: cx_ff <= qsg;
                  2'd1: cy_ff <= qsg;
                  default: cz_ff <= qsg;
               endcase
               axis_ff <= axis_ff + 1'b1; step_ff <= '0; rem_ff <= '0;
               neg_ff  <= (axis_ff == 2'd0) ? wy_ff[WsW-1] : wz_ff[WsW-1];
               mag_ff  <= ((axis_ff == 2'd0) ?
                          (wy_ff[WsW-1] ? -{wy_ff[WsW-1], wy_ff} : {1'b0, wy_ff}) :
                          (wz_ff[WsW-1] ? -{wz_ff[WsW-1], wz_ff} : {1'b0, wz_ff}))
                          + half_mt;
               acc_ff <= '0;
            end
            S_RD: idx_ff <= idx_ff + 1'b1;
            S_SQ: begin
               dx_ff <= 26'(27'(xr_ff) - cx_ff);
               dy_ff <= 26'(27'(yr_ff) - cy_ff);
               dz_ff <= 26'(27'(zr_ff) - cz_ff);
            end
            S_MUL: d2_ff <= 52'(dx_ff * dx_ff) + 52'(dy_ff * dy_ff) + 52'(dz_ff * dz_ff);
            S_ACC: begin
               acc_ff <= mac;
               if (idx_ff == cnt_ff) begin
                  num_ff <= mac; drem_ff <= '0; step_ff <= '0; dq_ff <= '0;
               end
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               drem_ff <= dtry[MtW+1] ? dsh : dtry[MtW:0];
               num_ff  <= {num_ff[AcW-2:0], 1'b0};
               dq_ff   <= qfin;
               if (step_ff == 7'(AcW - 1)) begin
                  sv_ff <= qfin; sres_ff <= '0; sbit_ff <= 64'h4000_0000_0000_0000;
               end
            end
            S_SQRT: if (sbit_ff != '0) begin
               if (sv_ff >= ssum) begin
                  sv_ff <= sv_ff - ssum; sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else sres_ff <= sres_ff >> 1;
               sbit_ff <= sbit_ff >> 2;
            end
            S_OUT: begin
               res_ff.radius        <= (mt_ff == '0) ? '0 : sres_ff[mwrg_pkg::RadW-1:0];
               res_ff.zero_mass     <= (mt_ff == '0);
               res_ff.atoms_dropped <= ovf_ff || drop_ff;
               rv_ff <= 1'b1; pstage_ff <= 1'b0; cnt_ff <= '0; mt_ff <= '0;
               ovf_ff <= 1'b0; wx_ff <= '0; wy_ff <= '0; wz_ff <= '0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
